### design/trs_pkg.sv
// Shared types and constants of the TRS transform matrix composer.
package trs_pkg;

  // Number of CORDIC micro-rotations, 8 to 24.
  localparam int TRIG_ITERATIONS = 16;
  localparam int ATAN_ENTRIES    = 24;

  // Latency of the sine/cosine unit: range reduction, iterations, rounding.
  localparam int CORDIC_LAT = TRIG_ITERATIONS + 2;
  // Register stages from acceptance to the saturated matrix entries.
  localparam int PIPE_DEPTH = CORDIC_LAT + 5;

  // Datapath widths.
  localparam int XY_W   = 33;
  localparam int Z_W    = 26;
  localparam int R_W    = 15;
  localparam int TRIG_W = 17;

  // Angle constants in Q9.6 degrees.
  localparam int DEG90  = 5760;
  localparam int DEG180 = 11520;
  localparam int DEG270 = 17280;
  localparam int DEG360 = 23040;

  localparam int ONE_Q15 = 32768;

  // CORDIC gain in Q2.30.
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;

  // Arctangent of 2^-i in units of 2^-16 degree.
  localparam logic signed [Z_W-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379, 26'sd117304,
    26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334, 26'sd3667, 26'sd1833,
    26'sd917, 26'sd458, 26'sd229, 26'sd115, 26'sd57, 26'sd29,
    26'sd14, 26'sd7, 26'sd4, 26'sd2, 26'sd1, 26'sd0
  };

  // One input transaction.
  typedef struct packed {
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } trs_in_t;

  // One result transaction: one matrix column.
  typedef struct packed {
    logic [1:0]         column_index;
    logic signed [31:0] row0_value;
    logic signed [31:0] row1_value;
    logic signed [31:0] row2_value;
    logic               last_column;
  } trs_out_t;

  // Cosine and sine of one angle in units of 2^-15.
  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } trs_trig_t;

endpackage

### design/trs_cordic.sv
// Pipelined degree-domain CORDIC giving cosine and sine of one Q9.6 angle.
module trs_cordic (
  input  logic               clk,
  input  logic signed [15:0] angle,
  output trs_pkg::trs_trig_t trig
);
  import trs_pkg::*;

  typedef enum logic [1:0] {
    SP_NONE  = 2'd0,
    SP_ZERO  = 2'd1,
    SP_POS90 = 2'd2,
    SP_NEG90 = 2'd3
  } trs_special_t;

  localparam logic signed [R_W-1:0] R_POS90 = R_W'(DEG90);
  localparam logic signed [R_W-1:0] R_NEG90 = R_W'(-DEG90);
  localparam logic signed [TRIG_W-1:0] T_ONE = TRIG_W'(ONE_Q15);
  localparam logic signed [TRIG_W-1:0] T_MONE = TRIG_W'(-ONE_Q15);

  logic [16:0]            wrap_v;
  logic [16:0]            red_a;
  logic signed [R_W-1:0]  red_r;
  logic                   red_neg;
  trs_special_t           red_sp;

  logic signed [R_W-1:0]  r0_r;
  logic                   ng0_r;
  trs_special_t           sp0_r;

  logic signed [XY_W-1:0] x_r [TRIG_ITERATIONS];
  logic signed [XY_W-1:0] y_r [TRIG_ITERATIONS];
  logic signed [Z_W-1:0]  z_r [TRIG_ITERATIONS];
  logic                   ng_r [TRIG_ITERATIONS];
  trs_special_t           sp_r [TRIG_ITERATIONS];

  logic signed [XY_W-1:0] x_rnd;
  logic signed [XY_W-1:0] y_rnd;
  trs_trig_t              trig_nxt;
  trs_trig_t              trig_r;

  // Round half up to 2^-15 and clamp to plus or minus one.
  function automatic logic signed [TRIG_W-1:0] clamp_trig(input logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] s;
    s = (v + 33'sd16384) >>> 15;
    if (s > 33'sd32768) begin
      return T_ONE;
    end else if (s < -33'sd32768) begin
      return T_MONE;
    end
    return s[TRIG_W-1:0];
  endfunction

  // Bring the angle into 0..360 degrees, then fold it into -90..90 degrees.
  always_comb begin
    wrap_v = 17'($signed({angle[15], angle}) + 18'sd46080);
    if (wrap_v >= 17'(3 * DEG360)) begin
      red_a = wrap_v - 17'(3 * DEG360);
    end else if (wrap_v >= 17'(2 * DEG360)) begin
      red_a = wrap_v - 17'(2 * DEG360);
    end else if (wrap_v >= 17'(DEG360)) begin
      red_a = wrap_v - 17'(DEG360);
    end else begin
      red_a = wrap_v;
    end
    red_neg = 1'b0;
    if (red_a > 17'(DEG90) && red_a < 17'(DEG270)) begin
      red_r   = R_W'(17'(DEG180) - red_a);
      red_neg = 1'b1;
    end else if (red_a >= 17'(DEG270)) begin
      red_r = R_W'(red_a - 17'(DEG360));
    end else begin
      red_r = R_W'(red_a);
    end
    if (red_r == '0) begin
      red_sp = SP_ZERO;
    end else if (red_r == R_POS90) begin
      red_sp = SP_POS90;
    end else if (red_r == R_NEG90) begin
      red_sp = SP_NEG90;
    end else begin
      red_sp = SP_NONE;
    end
  end

  // Range reduction register.
  always_ff @(posedge clk) begin
    r0_r  <= red_r;
    ng0_r <= red_neg;
    sp0_r <= red_sp;
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_iter
    logic signed [XY_W-1:0] xin;
    logic signed [XY_W-1:0] yin;
    logic signed [Z_W-1:0]  zin;
    logic                   ngin;
    trs_special_t           spin;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    if (i == 0) begin : g_first
      assign xin  = CORDIC_GAIN;
      assign yin  = '0;
      assign zin  = {r0_r[R_W-1], r0_r, 10'b0};
      assign ngin = ng0_r;
      assign spin = sp0_r;
    end else begin : g_next
      assign xin  = x_r[i-1];
      assign yin  = y_r[i-1];
      assign zin  = z_r[i-1];
      assign ngin = ng_r[i-1];
      assign spin = sp_r[i-1];
    end

    assign dx = yin >>> i;
    assign dy = xin >>> i;

    always_ff @(posedge clk) begin
      if (zin >= 0) begin
        x_r[i] <= xin - dx;
        y_r[i] <= yin + dy;
        z_r[i] <= zin - ATAN_TAB[i];
      end else begin
        x_r[i] <= xin + dx;
        y_r[i] <= yin - dy;
        z_r[i] <= zin + ATAN_TAB[i];
      end
      ng_r[i] <= ngin;
      sp_r[i] <= spin;
    end
  end

  // Final rounding, exact values at multiples of 90 degrees, quadrant sign.
  assign x_rnd = x_r[TRIG_ITERATIONS-1];
  assign y_rnd = y_r[TRIG_ITERATIONS-1];

  always_comb begin
    unique case (sp_r[TRIG_ITERATIONS-1])
      SP_ZERO: begin
        trig_nxt.cos_v = T_ONE;
        trig_nxt.sin_v = '0;
      end
      SP_POS90: begin
        trig_nxt.cos_v = '0;
        trig_nxt.sin_v = T_ONE;
      end
      SP_NEG90: begin
        trig_nxt.cos_v = '0;
        trig_nxt.sin_v = T_MONE;
      end
      default: begin
        trig_nxt.cos_v = clamp_trig(x_rnd);
        trig_nxt.sin_v = clamp_trig(y_rnd);
      end
    endcase
    if (ng_r[TRIG_ITERATIONS-1]) begin
      trig_nxt.cos_v = -trig_nxt.cos_v;
    end
  end

  always_ff @(posedge clk) begin
    trig_r <= trig_nxt;
  end

  assign trig = trig_r;

endmodule

### design/trs_transform_matrix_compose.sv
// Top level of the TRS transform matrix composer.
// Usage: a transaction on the input channel (start high while busy is low)
// carries a translation, three Q9.6 Euler angles in degrees and three
// per-axis scales. The block returns the upper 3x4 part of the column-major
// affine matrix as four result transactions, columns 0, 1, 2 and 3 in that
// order, each shown on out_data for one cycle with out_valid high.
// Column 0 appears once a transaction has passed the CORDIC, product,
// rounding, scale and saturation stages and the output register; the other
// columns follow on consecutive cycles, and last_column marks column 3.
// A new transaction is taken only once busy falls again, a pacing set by the
// single result port that carries one column per cycle; busy is raised after
// each acceptance. Inside, three CORDIC pipelines run one micro-rotation per
// stage, followed by product, rounding, scale and saturation stages.
// Reset clears all valid bits and the output strobe; no result is emitted
// until a new transaction is accepted. The receiver cannot stall.
module trs_transform_matrix_compose (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  trs_pkg::trs_in_t   in_data,
  output logic               out_valid,
  output trs_pkg::trs_out_t  out_data
);
  import trs_pkg::*;

  typedef struct packed {
    logic signed [31:0]       cycz;
    logic signed [31:0]       cysz;
    logic signed [31:0]       cxsz;
    logic signed [31:0]       cxcz;
    logic signed [31:0]       sxcy;
    logic signed [31:0]       sxsz;
    logic signed [31:0]       sxcz;
    logic signed [31:0]       cxcy;
    logic signed [TRIG_W-1:0] sy;
  } trs_pair_t;

  localparam int P3 = CORDIC_LAT + 2;
  localparam int P5 = CORDIC_LAT + 4;

  logic                  accept;
  logic [1:0]            gap_r;
  logic [PIPE_DEPTH-1:0] vld_r;
  trs_in_t               pay_r [PIPE_DEPTH];

  trs_trig_t             tx;
  trs_trig_t             ty;
  trs_trig_t             tz;

  trs_pair_t             p1_r;
  logic signed [31:0]    sxsy_r;
  logic signed [31:0]    cxsy_r;
  logic signed [TRIG_W-1:0] cz1_r;
  logic signed [TRIG_W-1:0] sz1_r;

  trs_pair_t             p2_r;
  logic signed [46:0]    sxsycz_r;
  logic signed [46:0]    sxsysz_r;
  logic signed [46:0]    cxsycz_r;
  logic signed [46:0]    cxsysz_r;

  logic signed [32:0]    e_nxt [3][3];
  logic signed [32:0]    e_r   [3][3];
  logic signed [63:0]    m_nxt [3][3];
  logic signed [63:0]    m_r   [3][3];
  logic signed [31:0]    s_r   [3][3];
  logic signed [31:0]    sc    [3];

  logic                  out_valid_r;
  trs_out_t              out_r;
  trs_out_t              col_r [3];
  logic [1:0]            cnt_r;

  // Round a triple product at 2^-45 half up to 2^-30.
  function automatic logic signed [32:0] rnd15(input logic signed [46:0] t);
    logic signed [46:0] s;
    s = (t + 47'sd16384) >>> 15;
    return s[32:0];
  endfunction

  // Round a scaled entry at 2^-46 half up to Q16.16 and saturate.
  function automatic logic signed [31:0] sat30(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = (p + 64'sd536870912) >>> 30;
    if (s > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (s < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

  // Input pacing: a new transaction is taken only while busy is low.
  assign accept = start && !busy;
  assign busy   = (gap_r != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= 2'd0;
      vld_r <= '0;
    end else begin
      if (accept) begin
        gap_r <= 2'd3;
      end else if (gap_r != 2'd0) begin
        gap_r <= gap_r - 2'd1;
      end
      vld_r <= {vld_r[PIPE_DEPTH-2:0], accept};
    end
  end

  // Translation and scale travel alongside the pipeline.
  always_ff @(posedge clk) begin
    pay_r[0] <= in_data;
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      pay_r[k] <= pay_r[k-1];
    end
  end

  // Sine and cosine of the three angles.
  trs_cordic u_cordic_x (.clk(clk), .angle(in_data.angle_x), .trig(tx));
  trs_cordic u_cordic_y (.clk(clk), .angle(in_data.angle_y), .trig(ty));
  trs_cordic u_cordic_z (.clk(clk), .angle(in_data.angle_z), .trig(tz));

  // Pairwise trig products.
  always_ff @(posedge clk) begin
    logic signed [33:0] f [10];
    f[0] = ty.cos_v * tz.cos_v;
    f[1] = ty.cos_v * tz.sin_v;
    f[2] = tx.cos_v * tz.sin_v;
    f[3] = tx.cos_v * tz.cos_v;
    f[4] = tx.sin_v * ty.cos_v;
    f[5] = tx.sin_v * tz.sin_v;
    f[6] = tx.sin_v * tz.cos_v;
    f[7] = tx.cos_v * ty.cos_v;
    f[8] = tx.sin_v * ty.sin_v;
    f[9] = tx.cos_v * ty.sin_v;
    p1_r.cycz <= f[0][31:0];
    p1_r.cysz <= f[1][31:0];
    p1_r.cxsz <= f[2][31:0];
    p1_r.cxcz <= f[3][31:0];
    p1_r.sxcy <= f[4][31:0];
    p1_r.sxsz <= f[5][31:0];
    p1_r.sxcz <= f[6][31:0];
    p1_r.cxcy <= f[7][31:0];
    p1_r.sy   <= ty.sin_v;
    sxsy_r    <= f[8][31:0];
    cxsy_r    <= f[9][31:0];
    cz1_r     <= tz.cos_v;
    sz1_r     <= tz.sin_v;
  end

  // Triple trig products.
  always_ff @(posedge clk) begin
    logic signed [48:0] g [4];
    g[0] = sxsy_r * cz1_r;
    g[1] = sxsy_r * sz1_r;
    g[2] = cxsy_r * cz1_r;
    g[3] = cxsy_r * sz1_r;
    sxsycz_r <= g[0][46:0];
    sxsysz_r <= g[1][46:0];
    cxsycz_r <= g[2][46:0];
    cxsysz_r <= g[3][46:0];
    p2_r     <= p1_r;
  end

  // Rotation entries at 2^-30, indexed by column then row.
  always_comb begin
    e_nxt[0][0] = 33'(p2_r.cycz);
    e_nxt[0][1] = 33'(p2_r.cysz);
    e_nxt[0][2] = -(33'(p2_r.sy) <<< 15);
    e_nxt[1][0] = rnd15(sxsycz_r) - 33'(p2_r.cxsz);
    e_nxt[1][1] = rnd15(sxsysz_r) + 33'(p2_r.cxcz);
    e_nxt[1][2] = 33'(p2_r.sxcy);
    e_nxt[2][0] = rnd15(cxsycz_r) + 33'(p2_r.sxsz);
    e_nxt[2][1] = rnd15(cxsysz_r) - 33'(p2_r.sxcz);
    e_nxt[2][2] = 33'(p2_r.cxcy);
  end

  always_ff @(posedge clk) begin
    e_r <= e_nxt;
  end

  // Column scaling.
  assign sc[0] = pay_r[P3].scale_x;
  assign sc[1] = pay_r[P3].scale_y;
  assign sc[2] = pay_r[P3].scale_z;

  always_comb begin
    logic signed [64:0] prod;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        prod        = e_r[k][j] * sc[k];
        m_nxt[k][j] = prod[63:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    m_r <= m_nxt;
  end

  // Rounding and saturation to Q16.16.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        s_r[k][j] <= sat30(m_r[k][j]);
      end
    end
  end

  // Column serializer: one column per cycle from the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= 2'd0;
    end else begin
      out_valid_r <= vld_r[P5] || (cnt_r != 2'd0);
      if (vld_r[P5]) begin
        cnt_r <= 2'd3;
      end else if (cnt_r != 2'd0) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vld_r[P5]) begin
      out_r    <= {2'd0, s_r[0][0], s_r[0][1], s_r[0][2], 1'b0};
      col_r[0] <= {2'd1, s_r[1][0], s_r[1][1], s_r[1][2], 1'b0};
      col_r[1] <= {2'd2, s_r[2][0], s_r[2][1], s_r[2][2], 1'b0};
      col_r[2] <= {2'd3, pay_r[P5].trans_x, pay_r[P5].trans_y, pay_r[P5].trans_z, 1'b1};
    end else begin
      out_r    <= col_r[0];
      col_r[0] <= col_r[1];
      col_r[1] <= col_r[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // An accepted transaction holds off the next one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after an accepted transaction");

  // Columns of one transaction come out on consecutive cycles.
  a_columns_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_column |=> out_valid)
    else $error("gap inside the columns of one transaction");

  a_column_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_column |=>
      out_data.column_index == $past(out_data.column_index) + 2'd1)
    else $error("column index out of order");

  // Only column 3 is marked as the last one.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_column == (out_data.column_index == 2'd3)))
    else $error("last_column does not match column index");

endmodule
